FILE: hw/rtl/swrm_pkg.sv
package swrm_pkg;

   localparam int DEPTH_DEF     = 128;
   localparam int TIME_BITS     = 32;
   localparam int UNIT_BITS     = 16;
   localparam int RATE_BITS     = 31;
   localparam int COUNT_BITS    = 8;
   localparam int TICKS_PER_SEC = 1000000;
   localparam int TPS_BITS      = $clog2(TICKS_PER_SEC + 1);

   localparam logic [RATE_BITS-1:0] RATE_MAX = '1;

   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_POINTS  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MEAS_SPAN   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RECORD_SPAN = 2'd2;

   localparam logic [COUNT_BITS-1:0] MAX_POINTS_RST = 8'd100;
   localparam logic [TIME_BITS-1:0]  SPAN_RST       = 32'd10000000;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_QMEAS,
      OP_QREC,
      OP_TICK
   } swrm_op_type;

   typedef struct packed {
      swrm_op_type          cmd;
      logic [TIME_BITS-1:0] now_time;
      logic [TIME_BITS-1:0] meas_time;
      logic [UNIT_BITS-1:0] units;
      logic [TIME_BITS-1:0] query_span;
   } swrm_req_type;

   typedef struct packed {
      logic [RATE_BITS-1:0]  rate;
      logic [TIME_BITS-1:0]  span_used;
      logic [COUNT_BITS-1:0] sample_count;
   } swrm_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TRIM,
      ST_ADD,
      ST_AGE,
      ST_AGE_CHK,
      ST_QUERY,
      ST_Q_RD,
      ST_Q_CHK,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV,
      ST_DONE
   } swrm_state_type;

   typedef struct packed {
      logic load_req;
      logic trim;
      logic add;
      logic age_clear;
      logic age_drop;
      logic q_init;
      logic q_rd;
      logic q_acc;
      logic mul;
      logic div_start;
      logic load_rsp;
   } swrm_cmd_type;

   typedef struct packed {
      swrm_op_type op;
      logic        held_zero;
      logic        rspan_zero;
      logic        age_over;
      logic        q_stop;
      logic        span_zero;
      logic        div_busy;
   } swrm_stat_type;

endpackage

FILE: hw/rtl/swrm_div.sv
module swrm_div import swrm_pkg::*; #(
   parameter int DVD_BITS = 2 * TIME_BITS,
   parameter int DVS_BITS = TIME_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DVD_BITS-1:0] dividend,
   input  logic [DVS_BITS-1:0] divisor,
   output logic                busy,
   output logic [DVD_BITS-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_BITS + 1);

   logic                busy_ff, busy_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DVS_BITS-1:0] rem_ff, rem_in;
   logic [DVD_BITS-1:0] quo_ff, quo_in;
   logic [DVS_BITS:0]   trial;
   logic [DVS_BITS:0]   diff;
   logic                fits;

   assign trial = {rem_ff, quo_ff[DVD_BITS-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_BITS);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
         quo_in = {quo_ff[DVD_BITS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

FILE: hw/rtl/swrm_dp.sv
module swrm_dp import swrm_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  swrm_req_type             req_data,
   output swrm_rsp_type             rsp_data,
   input  swrm_cmd_type             cmd,
   output swrm_stat_type            stat
);

   localparam int IDX_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);
   localparam int WRAP_BITS = CNT_BITS + 1;
   localparam int SUM_BITS  = UNIT_BITS + CNT_BITS;
   localparam int PROD_BITS = SUM_BITS + TPS_BITS;

   function automatic logic [IDX_BITS-1:0] ring_add(input logic [IDX_BITS-1:0] base,
                                                    input logic [CNT_BITS-1:0] ofs);
      logic [WRAP_BITS-1:0] s;
      s = WRAP_BITS'(base) + WRAP_BITS'(ofs);
      if (s >= WRAP_BITS'(DEPTH)) begin
         s = s - WRAP_BITS'(DEPTH);
      end
      return s[IDX_BITS-1:0];
   endfunction

   // configuration
   logic [COUNT_BITS-1:0] max_points_ff;
   logic [TIME_BITS-1:0]  meas_span_ff;
   logic [TIME_BITS-1:0]  record_span_ff;

   // current item
   swrm_op_type          op_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [TIME_BITS-1:0] meas_ff;
   logic [UNIT_BITS-1:0] units_ff;
   logic [TIME_BITS-1:0] qspan_ff;

   // ring pointers
   logic [IDX_BITS-1:0] oldest_ff, oldest_in;
   logic [CNT_BITS-1:0] held_ff, held_in;

   // sample memory
   logic [TIME_BITS-1:0] rec_mem_ff  [DEPTH];
   logic [TIME_BITS-1:0] meas_mem_ff [DEPTH];
   logic [UNIT_BITS-1:0] unit_mem_ff [DEPTH];
   logic [TIME_BITS-1:0] rd_rec_ff;
   logic [TIME_BITS-1:0] rd_meas_ff;
   logic [UNIT_BITS-1:0] rd_units_ff;

   // query walk
   logic [TIME_BITS-1:0] win_ff, win_in;
   logic [TIME_BITS-1:0] end_ff, end_in;
   logic [TIME_BITS-1:0] beg_ff, beg_in;
   logic [SUM_BITS-1:0]  sum_ff, sum_in;
   logic [IDX_BITS-1:0]  k_ff, k_in;
   logic                 first_ff, first_in;
   logic [TIME_BITS-1:0] span_ff, span_in;
   logic [PROD_BITS-1:0] prod_ff, prod_in;

   // result
   logic [RATE_BITS-1:0]  rate_ff, rate_in;
   logic [TIME_BITS-1:0]  rsp_span_ff;
   logic [COUNT_BITS-1:0] rsp_count_ff;

   logic [CNT_BITS-1:0]  lim;
   logic [CNT_BITS-1:0]  trim_excess;
   logic                 by_record;
   logic [TIME_BITS-1:0] rd_time;
   logic [TIME_BITS-1:0] age_diff;
   logic                 age_over;
   logic [TIME_BITS-1:0] walk_diff;
   logic                 walk_over;
   logic                 k_last;
   logic [IDX_BITS-1:0]  wr_addr;
   logic [IDX_BITS-1:0]  rd_addr;
   logic [IDX_BITS-1:0]  oldest_inc;
   logic                 add_drop;
   logic                 mem_we;
   logic                 div_busy;
   logic [PROD_BITS-1:0] quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_points_ff  <= MAX_POINTS_RST;
         meas_span_ff   <= SPAN_RST;
         record_span_ff <= SPAN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_POINTS:  max_points_ff  <= csr_wdata[COUNT_BITS-1:0];
            CSR_MEAS_SPAN:   meas_span_ff   <= csr_wdata[TIME_BITS-1:0];
            CSR_RECORD_SPAN: record_span_ff <= csr_wdata[TIME_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= req_data.cmd;
         now_ff   <= req_data.now_time;
         meas_ff  <= req_data.meas_time;
         units_ff <= req_data.units;
         qspan_ff <= req_data.query_span;
      end
   end

   assign lim         = (32'(max_points_ff) > 32'(DEPTH)) ? CNT_BITS'(DEPTH)
                                                        : CNT_BITS'(max_points_ff);
   assign trim_excess = held_ff - lim;
   assign by_record   = (op_ff == OP_QREC);
   assign rd_time     = by_record ? rd_rec_ff : rd_meas_ff;
   assign age_diff    = now_ff - rd_rec_ff;
   assign age_over    = age_diff > record_span_ff;
   assign walk_diff   = first_ff ? '0 : end_ff - rd_time;
   assign walk_over   = walk_diff > win_ff;
   assign k_last      = (k_ff == '0);
   assign wr_addr     = ring_add(oldest_ff, held_ff);
   assign rd_addr     = cmd.q_rd ? ring_add(oldest_ff, CNT_BITS'(k_ff)) : oldest_ff;
   assign oldest_inc  = (oldest_ff == IDX_BITS'(DEPTH - 1)) ? '0 : oldest_ff + 1'b1;
   assign add_drop    = held_ff >= lim;
   assign mem_we      = cmd.add && (lim != '0);

   always_comb begin
      oldest_in = oldest_ff;
      held_in   = held_ff;
      if (cmd.trim) begin
         if (held_ff > lim) begin
            oldest_in = ring_add(oldest_ff, trim_excess);
            held_in   = lim;
         end
      end else if (mem_we) begin
         // the new sample lands at oldest+held whether or not the oldest is dropped
         if (add_drop) begin
            oldest_in = oldest_inc;
         end else begin
            held_in = held_ff + 1'b1;
         end
      end else if (cmd.age_clear) begin
         held_in = '0;
      end else if (cmd.age_drop) begin
         oldest_in = oldest_inc;
         held_in   = held_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         held_ff   <= '0;
      end else begin
         oldest_ff <= oldest_in;
         held_ff   <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         rec_mem_ff[wr_addr]  <= now_ff;
         meas_mem_ff[wr_addr] <= meas_ff;
         unit_mem_ff[wr_addr] <= units_ff;
      end
      rd_rec_ff   <= rec_mem_ff[rd_addr];
      rd_meas_ff  <= meas_mem_ff[rd_addr];
      rd_units_ff <= unit_mem_ff[rd_addr];
   end

   always_comb begin
      win_in   = win_ff;
      end_in   = end_ff;
      beg_in   = beg_ff;
      sum_in   = sum_ff;
      k_in     = k_ff;
      first_in = first_ff;
      span_in  = span_ff;
      prod_in  = prod_ff;
      if (cmd.load_req) begin
         span_in = '0;
      end
      if (cmd.q_init) begin
         if (qspan_ff != '0) begin
            win_in = qspan_ff;
         end else begin
            win_in = by_record ? record_span_ff : meas_span_ff;
         end
         k_in     = IDX_BITS'(held_ff - 1'b1);
         first_in = 1'b1;
         sum_in   = '0;
      end
      if (cmd.q_acc && !walk_over) begin
         sum_in   = sum_ff + SUM_BITS'(rd_units_ff);
         beg_in   = rd_time;
         first_in = 1'b0;
         if (first_ff) begin
            end_in = rd_time;
         end
         if (!k_last) begin
            k_in = k_ff - 1'b1;
         end
      end
      if (cmd.mul) begin
         span_in = end_ff - beg_ff;
         prod_in = PROD_BITS'(sum_ff) * PROD_BITS'(TICKS_PER_SEC);
      end
   end

   always_ff @(posedge clock) begin
      win_ff   <= win_in;
      end_ff   <= end_in;
      beg_ff   <= beg_in;
      sum_ff   <= sum_in;
      k_ff     <= k_in;
      first_ff <= first_in;
      span_ff  <= span_in;
      prod_ff  <= prod_in;
   end

   swrm_div #(
      .DVD_BITS(PROD_BITS),
      .DVS_BITS(TIME_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (span_ff),
      .busy     (div_busy),
      .quotient (quo)
   );

   always_comb begin
      if (span_ff == '0) begin
         rate_in = '0;
      end else if (quo > PROD_BITS'(RATE_MAX)) begin
         rate_in = RATE_MAX;
      end else begin
         rate_in = quo[RATE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rate_ff      <= rate_in;
         rsp_span_ff  <= span_ff;
         rsp_count_ff <= COUNT_BITS'(held_ff);
      end
   end

   assign rsp_data.rate         = rate_ff;
   assign rsp_data.span_used    = rsp_span_ff;
   assign rsp_data.sample_count = rsp_count_ff;

   assign stat.op         = op_ff;
   assign stat.held_zero  = (held_ff == '0);
   assign stat.rspan_zero = (record_span_ff == '0);
   assign stat.age_over   = age_over;
   assign stat.q_stop     = walk_over || k_last;
   assign stat.span_zero  = (span_ff == '0);
   assign stat.div_busy   = div_busy;

endmodule

FILE: hw/rtl/swrm_ctrl.sv
module swrm_ctrl import swrm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  swrm_stat_type stat,
   output swrm_cmd_type  cmd
);

   swrm_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_TRIM;
            end
         end
         ST_TRIM: begin
            unique case (stat.op)
               OP_ADD:   state_in = ST_ADD;
               OP_TICK:  state_in = ST_AGE;
               OP_QMEAS: state_in = ST_QUERY;
               OP_QREC:  state_in = ST_QUERY;
            endcase
         end
         ST_ADD: begin
            state_in = ST_AGE;
         end
         ST_AGE: begin
            state_in = (stat.rspan_zero || stat.held_zero) ? ST_DONE : ST_AGE_CHK;
         end
         ST_AGE_CHK: begin
            state_in = stat.age_over ? ST_AGE : ST_DONE;
         end
         ST_QUERY: begin
            state_in = stat.held_zero ? ST_DONE : ST_Q_RD;
         end
         ST_Q_RD: begin
            state_in = ST_Q_CHK;
         end
         ST_Q_CHK: begin
            state_in = stat.q_stop ? ST_MUL : ST_Q_RD;
         end
         ST_MUL: begin
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            state_in = stat.span_zero ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            if (!stat.div_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:    cmd.load_req  = req_valid;
         ST_TRIM:    cmd.trim      = 1'b1;
         ST_ADD:     cmd.add       = 1'b1;
         ST_AGE:     cmd.age_clear = stat.rspan_zero;
         ST_AGE_CHK: cmd.age_drop  = stat.age_over;
         ST_QUERY:   cmd.q_init    = !stat.held_zero;
         ST_Q_RD:    cmd.q_rd      = 1'b1;
         ST_Q_CHK:   cmd.q_acc     = 1'b1;
         ST_MUL:     cmd.mul       = 1'b1;
         ST_DIV_GO:  cmd.div_start = !stat.span_zero;
         ST_DIV:     cmd.mul       = 1'b0;
         ST_DONE:    cmd.load_rsp  = out_free;
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hw/rtl/sliding_window_rate_meter.sv
// channel  dir  handshake              payload
// req      in   req_valid / req_ready  swrm_req_type (cmd, times, units, span)
// rsp      out  rsp_valid / rsp_ready  swrm_rsp_type (rate, span_used, count)
// csr      in   csr_we                 csr_index, csr_wdata
//
// add item: trim, add the sample, then age out old samples; tick item: trim, then age out
// query item: trim, then straight to the result with an empty ring, else a read and a
//   check per walked sample, a multiply, and the bit-serial divider when the span is nonzero
// sync reset clears the controller and ring pointers; sample memory is not cleared
// a result waits in the output register while the next item is accepted;
//   a second result holds the controller until the first one is taken
module sliding_window_rate_meter import swrm_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  swrm_req_type             req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output swrm_rsp_type             rsp_data,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   swrm_cmd_type  cmd;
   swrm_stat_type stat;

   swrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   swrm_dp #(
      .DEPTH(DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

FILE: hw/rtl/swrm_chk.sv
module swrm_chk import swrm_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input swrm_rsp_type rsp_data
);

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown after reset");

   // one item at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready held after accepting an item");

   // a new result frees the input side
   a_result_frees_input: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result appeared while still busy");

   // zero span gives zero rate
   a_zero_span_rate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.span_used == '0) |-> rsp_data.rate == '0)
      else $error("nonzero rate with zero span");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind sliding_window_rate_meter swrm_chk u_chk (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top import swrm_pkg::*;;

   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 20000;
   localparam int TAIL_CYCLES = 400;

   class rate_scoreboard;
      bit [TIME_BITS-1:0] rec_t[DEPTH_DEF];
      bit [TIME_BITS-1:0] meas_t[DEPTH_DEF];
      bit [UNIT_BITS-1:0] unit_c[DEPTH_DEF];
      int unsigned        oldest;
      int unsigned        held;
      bit [7:0]           max_pts;
      bit [TIME_BITS-1:0] mspan;
      bit [TIME_BITS-1:0] rspan;
      swrm_rsp_type       pending[$];
      int                 errors;

      function new();
         oldest  = 0;
         held    = 0;
         max_pts = MAX_POINTS_RST;
         mspan   = SPAN_RST;
         rspan   = SPAN_RST;
         errors  = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_MAX_POINTS:  max_pts = data[7:0];
            CSR_MEAS_SPAN:   mspan   = data;
            CSR_RECORD_SPAN: rspan   = data;
            default: ;
         endcase
      endfunction

      function void drop_oldest();
         if (held != 0) begin
            oldest = (oldest + 1) % DEPTH_DEF;
            held--;
         end
      endfunction

      function void age_ring(bit [TIME_BITS-1:0] now);
         bit [TIME_BITS-1:0] age;
         if (rspan == 0) begin
            held = 0;
            return;
         end
         while (held > 0) begin
            age = now - rec_t[oldest];
            if (age <= rspan) break;
            drop_oldest();
         end
      endfunction

      function void window_rate(bit by_rec, bit [TIME_BITS-1:0] qspan,
                                output bit [RATE_BITS-1:0] rate_o,
                                output bit [TIME_BITS-1:0] span_o);
         bit [TIME_BITS-1:0] win, t_end, t_beg, t_k, gap;
         bit [63:0]          sum, q;
         int unsigned        k, s;
         rate_o = '0;
         span_o = '0;
         if (held == 0) return;
         win   = (qspan != 0) ? qspan : (by_rec ? rspan : mspan);
         s     = (oldest + held - 1) % DEPTH_DEF;
         t_end = by_rec ? rec_t[s] : meas_t[s];
         t_beg = t_end;
         sum   = 0;
         for (k = held; k > 0; k--) begin
            s    = (oldest + k - 1) % DEPTH_DEF;
            t_k  = by_rec ? rec_t[s] : meas_t[s];
            gap  = t_end - t_k;
            if (gap > win) break;
            sum   = sum + unit_c[s];
            t_beg = t_k;
         end
         span_o = t_end - t_beg;
         if (span_o == 0) return;
         q = (sum * TICKS_PER_SEC) / span_o;
         rate_o = (q > RATE_MAX) ? RATE_MAX : q[RATE_BITS-1:0];
      endfunction

      function void note_item(swrm_req_type r);
         swrm_rsp_type       exp_r;
         int unsigned        lim, s;
         bit [RATE_BITS-1:0] rate_w;
         bit [TIME_BITS-1:0] span_w;
         lim    = (max_pts > DEPTH_DEF) ? DEPTH_DEF : max_pts;
         rate_w = '0;
         span_w = '0;
         while (held > lim) drop_oldest();
         case (r.cmd)
            OP_ADD: begin
               if (lim > 0) begin
                  if (held >= lim) drop_oldest();
                  s = (oldest + held) % DEPTH_DEF;
                  rec_t[s]  = r.now_time;
                  meas_t[s] = r.meas_time;
                  unit_c[s] = r.units;
                  held++;
               end
               age_ring(r.now_time);
            end
            OP_TICK: age_ring(r.now_time);
            default: window_rate(r.cmd == OP_QREC, r.query_span, rate_w, span_w);
         endcase
         exp_r.rate         = rate_w;
         exp_r.span_used    = span_w;
         exp_r.sample_count = held[COUNT_BITS-1:0];
         pending.push_back(exp_r);
      endfunction

      function void check_result(swrm_rsp_type got);
         swrm_rsp_type exp_r;
         if (pending.size() == 0) begin
            $error("result with no item waiting: rate %0d span_used %0d sample_count %0d",
                   got.rate, got.span_used, got.sample_count);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (got.rate !== exp_r.rate) begin
            $error("rate: expected %0d, got %0d", exp_r.rate, got.rate);
            errors++;
         end
         if (got.span_used !== exp_r.span_used) begin
            $error("span_used: expected %0d, got %0d", exp_r.span_used, got.span_used);
            errors++;
         end
         if (got.sample_count !== exp_r.sample_count) begin
            $error("sample_count: expected %0d, got %0d", exp_r.sample_count, got.sample_count);
            errors++;
         end
      endfunction

      function bit drained();
         return pending.size() == 0;
      endfunction

      function void final_check();
         if (pending.size() != 0) begin
            $error("%0d expected results never arrived", pending.size());
            errors++;
         end
      endfunction
   endclass

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   swrm_req_type             req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   swrm_rsp_type             rsp_data;
   logic                     csr_we    = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   rate_scoreboard     sb;
   int                 send_idle_pct  = 0;
   int                 recv_stall_pct = 0;
   int                 quiet_cycles   = 0;
   bit [TIME_BITS-1:0] tb_now;
   bit [TIME_BITS-1:0] meas_off;
   int unsigned        step_max;

   sliding_window_rate_meter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL sliding_window_rate_meter");
            $finish;
         end
      end
   end

   function automatic swrm_req_type mk_item(swrm_op_type c, bit [31:0] nt, bit [31:0] mt,
                                            bit [15:0] u, bit [31:0] qs);
      swrm_req_type r;
      r.cmd        = c;
      r.now_time   = nt;
      r.meas_time  = mt;
      r.units      = u;
      r.query_span = qs;
      return r;
   endfunction

   function automatic swrm_req_type build_item(bit noisy);
      swrm_req_type r;
      int unsigned  pick;
      r.cmd        = OP_ADD;
      r.now_time   = $urandom;
      r.meas_time  = $urandom;
      r.units      = 16'($urandom);
      r.query_span = $urandom;
      if (noisy) begin
         r.cmd = swrm_op_type'($urandom_range(0, 3));
         return r;
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) r.cmd = OP_ADD;
      else if (pick < 70) r.cmd = OP_QMEAS;
      else if (pick < 90) r.cmd = OP_QREC;
      else r.cmd = OP_TICK;
      if (r.cmd == OP_ADD || r.cmd == OP_TICK) tb_now += $urandom_range(0, step_max);
      r.now_time  = tb_now;
      r.meas_time = tb_now + meas_off;
      if ($urandom_range(0, 4) == 0) r.meas_time += $urandom_range(0, step_max);
      case ($urandom_range(0, 3))
         0: r.units = 16'($urandom_range(0, 65535));
         1: r.units = 16'($urandom_range(0, 100));
         2: r.units = 16'hFFFF;
         default: ;
      endcase
      case ($urandom_range(0, 3))
         0: r.query_span = '0;
         1: r.query_span = $urandom_range(0, step_max * 8);
         2: r.query_span = $urandom;
         default: r.query_span = $urandom_range(1, step_max * 64);
      endcase
      return r;
   endfunction

   task automatic send_item(swrm_req_type item);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_item(item);
   endtask

   task automatic wait_results_done();
      @(negedge clock);
      req_valid <= 1'b0;
      while (!sb.drained()) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.write_reg(idx, data);
   endtask

   task automatic configure(bit [7:0] mp, bit [31:0] ms, bit [31:0] rs);
      bit [31:0] junk;
      junk = $urandom;
      write_csr(CSR_MAX_POINTS, {junk[31:8], mp});
      write_csr(CSR_MEAS_SPAN, ms);
      write_csr(CSR_RECORD_SPAN, rs);
   endtask

   task automatic run_phase(int n, int idle_s, int stall_r, int unsigned step);
      bit noisy;
      send_idle_pct  = idle_s;
      recv_stall_pct = stall_r;
      step_max       = step;
      tb_now         = $urandom;
      meas_off       = $urandom;
      repeat (n) begin
         noisy = ($urandom_range(0, 99) < 10);
         send_item(build_item(noisy));
         if ($urandom_range(0, 99) == 0) wait_results_done();
      end
      wait_results_done();
   endtask

   initial begin
      int          idle_tab[4];
      int          stall_tab[4];
      int unsigned rs_rand;
      idle_tab  = '{0, 85, 0, 7};
      stall_tab = '{0, 0, 85, 7};
      sb = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty ring, wrapped times, saturation, zero window
      send_item(mk_item(OP_QMEAS, 32'd0, 32'd0, 16'd0, 32'd0));
      send_item(mk_item(OP_QREC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
      send_item(mk_item(OP_TICK, 32'd0, 32'd0, 16'd0, 32'd0));
      send_item(mk_item(OP_ADD, 32'd0, 32'd0, 16'd0, 32'd0));
      send_item(mk_item(OP_ADD, 32'd1, 32'hFFFF_FFFF, 16'hFFFF, 32'd0));
      send_item(mk_item(OP_ADD, 32'd2, 32'd2, 16'hFFFF, 32'd0));
      send_item(mk_item(OP_QMEAS, 32'd2, 32'd0, 16'd0, 32'd0));
      send_item(mk_item(OP_QMEAS, 32'd2, 32'd0, 16'd0, 32'd1));
      send_item(mk_item(OP_QREC, 32'd2, 32'd0, 16'd0, 32'hFFFF_FFFF));
      send_item(mk_item(OP_QREC, 32'd2, 32'd0, 16'd0, 32'd0));
      send_item(mk_item(OP_ADD, 32'd10000000, 32'd10000000, 16'd1, 32'd0));
      send_item(mk_item(OP_TICK, 32'd10000001, 32'd0, 16'd0, 32'd0));
      send_item(mk_item(OP_TICK, 32'hFFFF_FFFF, 32'd0, 16'd0, 32'd0));
      send_item(mk_item(OP_QREC, 32'd0, 32'd0, 16'd0, 32'd0));
      send_item(mk_item(OP_ADD, 32'hFFFF_FFF0, 32'd0, 16'd12345, 32'd0));
      send_item(mk_item(OP_ADD, 32'd5, 32'd20, 16'd1, 32'd0));
      send_item(mk_item(OP_QREC, 32'd5, 32'd0, 16'd0, 32'd0));
      send_item(mk_item(OP_QMEAS, 32'd5, 32'd0, 16'd0, 32'hFFFF_FFFF));
      send_item(mk_item(OP_TICK, 32'd6, 32'd0, 16'd0, 32'd0));
      wait_results_done();

      run_phase(250, 0, 0, 200000);
      configure(8'd128, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      run_phase(250, 85, 0, 3);
      // limit lowered while the ring is full
      configure(8'd5, 32'd0, 32'd1000);
      run_phase(200, 0, 85, 400);
      configure(8'd255, $urandom, 32'd0);
      write_csr(CSR_UNUSED, $urandom);
      run_phase(100, 7, 7, 1000);
      configure(8'd1, 32'd50, 32'd100000);
      run_phase(150, 0, 0, 50);
      configure(8'd0, 32'd1000, 32'd1000);
      run_phase(80, 7, 7, 100);
      for (int i = 0; i < 5; i++) begin
         rs_rand = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(1, 2000000);
         configure(8'($urandom_range(1, 128)), $urandom_range(0, 1000000), rs_rand);
         run_phase(150, idle_tab[i % 4], stall_tab[i % 4], $urandom_range(1, 20000));
      end

      wait_results_done();
      repeat (TAIL_CYCLES) @(posedge clock);
      sb.final_check();
      if (sb.errors == 0) begin
         $display("PASS sliding_window_rate_meter");
      end else begin
         $display("FAIL sliding_window_rate_meter");
      end
      $finish;
   end

endmodule
